>>> rtl/cntla_pkg.sv
// Package for the CAN node table lookup and allocate unit.
// Holds field widths, special identifiers, result codes and the entry write controls.
// No dependencies.
package cntla_pkg;

  localparam int ID_W     = 29;
  localparam int INDEX_W  = 8;
  localparam int SHORT_W  = 24;
  localparam int UNIQUE_W = 40;
  localparam int TIME_W   = 32;
  localparam int GROUP_W  = 5;
  localparam int SLOTNUM_W = 3;

  localparam int GROUPS_DEFAULT          = 8;
  localparam int SLOTS_PER_GROUP_DEFAULT = 8;
  localparam int INDEX_COUNT_DEFAULT     = 16;

  localparam logic [ID_W-1:0] BUZZER_ID = ID_W'(32'h1D1);
  localparam logic [ID_W-1:0] STD_ID_0  = ID_W'(32'h520);
  localparam logic [ID_W-1:0] STD_ID_1  = ID_W'(32'h521);
  localparam logic [ID_W-1:0] STD_ID_2  = ID_W'(32'h523);
  localparam logic [ID_W-1:0] STD_ID_3  = ID_W'(32'h525);
  localparam logic [ID_W-1:0] STD_ID_4  = ID_W'(32'h530);

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [2:0] {
    DISP_BUZZER  = 3'd0,
    DISP_STD     = 3'd1,
    DISP_DROP    = 3'd2,
    DISP_UNIQUE  = 3'd3,
    DISP_SHORT   = 3'd4,
    DISP_CREATED = 3'd5,
    DISP_EVICTED = 3'd6,
    DISP_NOSPACE = 3'd7
  } disp_t;

  typedef struct packed {
    logic set_valid;
    logic wr_short;
    logic wr_unique;
    logic wr_seen;
  } entry_wr_t;

endpackage

>>> rtl/cntla_if.sv
// Channel interfaces for the CAN node table lookup and allocate unit.
// Depends on cntla_pkg for field widths and the result code type.
interface cntla_req_if import cntla_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     frame_id;
  logic [INDEX_W-1:0]  index_byte;
  logic [UNIQUE_W-1:0] unique_bytes;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, frame_id, index_byte, unique_bytes, now_ms, input ready);
  modport sink (input valid, frame_id, index_byte, unique_bytes, now_ms, output ready);
endinterface

interface cntla_rsp_if import cntla_pkg::*; ();
  logic                 valid;
  logic                 ready;
  disp_t                disposition;
  logic [GROUP_W-1:0]   group_number;
  logic [SLOTNUM_W-1:0] slot_number;

  modport source (output valid, disposition, group_number, slot_number, input ready);
  modport sink (input valid, disposition, group_number, slot_number, output ready);
endinterface

>>> rtl/can_node_table_lookup_allocate_unit.sv
// Top level of the CAN node table lookup and allocate unit.
// Uses cntla_pkg, cntla_req_if, cntla_rsp_if, cntla_entry_store and cntla_scan.
//
// The frame channel takes one received frame per request: identifier, index byte,
// unique id bytes and the millisecond time. The result channel returns one
// disposition, group number and slot number per frame, in order.
// Buzzer and standard identifiers and groups out of range skip the table and go
// straight to the output state. Table frames are scanned one slot per
// cycle through the entry memory read port, then pass through the drain and
// decide states: a hit goes on to the write state, a frame that finds no space
// straight to the output state, and a new or evicted entry first through the
// clear state, the sweep that clears the entry's per-index times through that
// memory's single write port.
// The unit handles one frame at a time; frame.ready is high only while it is idle.
// A finished result sits in the output register, and the next frame is accepted
// while it waits; the unit holds a further result until the receiver takes it.
// Synchronous reset clears the valid flags and all control state; no clearing pass
// runs, since per-index times are cleared whenever an entry is created.
module can_node_table_lookup_allocate_unit import cntla_pkg::*; #(
  parameter int GROUPS          = GROUPS_DEFAULT,
  parameter int SLOTS_PER_GROUP = SLOTS_PER_GROUP_DEFAULT,
  parameter int INDEX_COUNT     = INDEX_COUNT_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  cntla_req_if.sink   frame,
  cntla_rsp_if.source result
);

  localparam int ENTRY_COUNT = GROUPS * SLOTS_PER_GROUP;
  localparam int SLOT_W  = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;
  localparam int ENTRY_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int IDX_W   = (INDEX_COUNT > 1) ? $clog2(INDEX_COUNT) : 1;
  localparam int IX_COUNT = ENTRY_COUNT * INDEX_COUNT;
  localparam int IX_W    = (IX_COUNT > 1) ? $clog2(IX_COUNT) : 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_CLEAR  = 7'b0010000,
    S_WRITE  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;

  logic [SHORT_W-1:0]  short_id;
  logic [UNIQUE_W-1:0] unique_id;
  logic [INDEX_W-1:0]  index;
  logic [TIME_W-1:0]   now;
  logic [GROUP_W-1:0]  group;
  logic [ENTRY_W-1:0]  base;
  logic [SLOT_W-1:0]   cnt;
  logic [SLOT_W-1:0]   sel_slot;
  logic [IDX_W-1:0]    clr_cnt;
  logic [IX_W-1:0]     ix_base;
  disp_t               res_disp;
  logic                step;
  logic [SLOT_W-1:0]   step_slot;

  logic                accept;
  logic [GROUP_W-1:0]  in_group;
  logic                is_std;
  logic                creating;
  logic                index_in_range;

  entry_wr_t           ent_wr;
  logic [ENTRY_W-1:0]  ent_addr;
  logic                ent_valid;
  logic [SHORT_W-1:0]  ent_short_id;
  logic [UNIQUE_W-1:0] ent_unique_id;
  logic [TIME_W-1:0]   ent_seen;

  disp_t               scan_disp;
  logic [SLOT_W-1:0]   scan_slot;
  logic [ENTRY_W-1:0]  scan_entry;

  logic                ix_we;
  logic [IX_W-1:0]     ix_addr;
  logic [TIME_W-1:0]   ix_data;
  logic [TIME_W-1:0]   index_seen_mem [IX_COUNT];

  assign frame.ready = (state == S_IDLE);
  assign accept      = frame.valid && frame.ready;
  assign in_group    = frame.frame_id[ID_W-1:ID_W-GROUP_W];
  assign is_std      = (frame.frame_id == STD_ID_0) || (frame.frame_id == STD_ID_1) ||
                       (frame.frame_id == STD_ID_2) || (frame.frame_id == STD_ID_3) ||
                       (frame.frame_id == STD_ID_4);
  assign creating    = (res_disp == DISP_CREATED) || (res_disp == DISP_EVICTED);
  assign index_in_range = ({1'b0, index} < (INDEX_W + 1)'(INDEX_COUNT));
  assign scan_entry  = base + ENTRY_W'(scan_slot);

  always_comb begin
    ent_wr    = '0;
    ent_addr  = base + ENTRY_W'(cnt);
    ix_we     = 1'b0;
    ix_addr   = ix_base + IX_W'(clr_cnt);
    ix_data   = '0;
    if (state == S_CLEAR) begin
      ix_we = 1'b1;
    end
    if (state == S_WRITE) begin
      ent_addr         = base + ENTRY_W'(sel_slot);
      ent_wr.set_valid = creating;
      ent_wr.wr_short  = creating;
      ent_wr.wr_unique = creating || ((index == '0) && (unique_id != '0));
      ent_wr.wr_seen   = 1'b1;
      ix_we            = index_in_range;
      ix_addr          = ix_base + IX_W'(index);
      ix_data          = now;
    end
  end

  always_ff @(posedge clk) begin
    if (ix_we) begin
      index_seen_mem[ix_addr] <= ix_data;
    end
  end

  cntla_entry_store #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .addr         (ent_addr),
    .wr           (ent_wr),
    .wr_short_id  (short_id),
    .wr_unique_id (unique_id),
    .wr_seen      (now),
    .rd_valid     (ent_valid),
    .rd_short_id  (ent_short_id),
    .rd_unique_id (ent_unique_id),
    .rd_seen      (ent_seen)
  );

  cntla_scan #(
    .SLOTS_PER_GROUP (SLOTS_PER_GROUP)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .start         (accept),
    .step          (step),
    .step_slot     (step_slot),
    .ent_valid     (ent_valid),
    .ent_short_id  (ent_short_id),
    .ent_unique_id (ent_unique_id),
    .ent_seen      (ent_seen),
    .short_id      (short_id),
    .unique_id     (unique_id),
    .disp          (scan_disp),
    .slot          (scan_slot)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      short_id  <= frame.frame_id[SHORT_W-1:0];
      unique_id <= frame.unique_bytes;
      index     <= frame.index_byte;
      now       <= frame.now_ms;
      group     <= in_group;
      base      <= ENTRY_W'(int'(in_group) * SLOTS_PER_GROUP);
    end
    step_slot <= cnt;
    if (state == S_DECIDE) begin
      ix_base <= IX_W'(int'(scan_entry) * INDEX_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= 1'b0;
      cnt          <= '0;
      clr_cnt      <= '0;
      sel_slot     <= '0;
      res_disp     <= DISP_NOSPACE;
      result.valid <= 1'b0;
    end else begin
      step <= (state == S_SCAN);
      if ((state == S_OUT) && (!result.valid || result.ready)) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt      <= '0;
            sel_slot <= '0;
            if (frame.frame_id == BUZZER_ID) begin
              res_disp <= DISP_BUZZER;
              state    <= S_OUT;
            end else if (is_std) begin
              res_disp <= DISP_STD;
              state    <= S_OUT;
            end else if ({1'b0, in_group} >= (GROUP_W + 1)'(GROUPS)) begin
              res_disp <= DISP_DROP;
              state    <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == SLOT_W'(SLOTS_PER_GROUP - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          res_disp <= scan_disp;
          sel_slot <= scan_slot;
          clr_cnt  <= '0;
          if ((scan_disp == DISP_CREATED) || (scan_disp == DISP_EVICTED)) begin
            state <= S_CLEAR;
          end else if (scan_disp == DISP_NOSPACE) begin
            state <= S_OUT;
          end else begin
            state <= S_WRITE;
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IDX_W'(INDEX_COUNT - 1)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!result.valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!result.valid || result.ready)) begin
      result.disposition  <= res_disp;
      result.group_number <= group;
      result.slot_number  <= SLOTNUM_W'(sel_slot);
    end
  end

endmodule

>>> rtl/cntla_entry_store.sv
// Entry store: valid flags plus short id, unique id and last-seen memories.
// One shared address for the registered read and the field-masked write; uses cntla_pkg.
module cntla_entry_store import cntla_pkg::*; #(
  parameter int ENTRY_COUNT = GROUPS_DEFAULT * SLOTS_PER_GROUP_DEFAULT,
  localparam int ENTRY_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ENTRY_W-1:0]  addr,
  input  entry_wr_t           wr,
  input  logic [SHORT_W-1:0]  wr_short_id,
  input  logic [UNIQUE_W-1:0] wr_unique_id,
  input  logic [TIME_W-1:0]   wr_seen,
  output logic                rd_valid,
  output logic [SHORT_W-1:0]  rd_short_id,
  output logic [UNIQUE_W-1:0] rd_unique_id,
  output logic [TIME_W-1:0]   rd_seen
);

  logic [ENTRY_COUNT-1:0] valid;
  logic [SHORT_W-1:0]     short_mem  [ENTRY_COUNT];
  logic [UNIQUE_W-1:0]    unique_mem [ENTRY_COUNT];
  logic [TIME_W-1:0]      seen_mem   [ENTRY_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.set_valid) begin
        valid[addr] <= 1'b1;
      end
      rd_valid <= valid[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.wr_short) begin
      short_mem[addr] <= wr_short_id;
    end
    rd_short_id <= short_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (wr.wr_unique) begin
      unique_mem[addr] <= wr_unique_id;
    end
    rd_unique_id <= unique_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (wr.wr_seen) begin
      seen_mem[addr] <= wr_seen;
    end
    rd_seen <= seen_mem[addr];
  end

endmodule

>>> rtl/cntla_scan.sv
// Slot scan unit: compares one stored entry per cycle against the request.
// Tracks first unique hit, first short hit, first free slot and oldest entry; uses cntla_pkg.
module cntla_scan import cntla_pkg::*; #(
  parameter int SLOTS_PER_GROUP = SLOTS_PER_GROUP_DEFAULT,
  localparam int SLOT_W = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                step,
  input  logic [SLOT_W-1:0]   step_slot,
  input  logic                ent_valid,
  input  logic [SHORT_W-1:0]  ent_short_id,
  input  logic [UNIQUE_W-1:0] ent_unique_id,
  input  logic [TIME_W-1:0]   ent_seen,
  input  logic [SHORT_W-1:0]  short_id,
  input  logic [UNIQUE_W-1:0] unique_id,
  output disp_t               disp,
  output logic [SLOT_W-1:0]   slot
);

  logic              uhit, shit, free, old;
  logic [SLOT_W-1:0] uslot, sslot, fslot, oslot;
  logic [TIME_W-1:0] old_time;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      uhit     <= 1'b0;
      shit     <= 1'b0;
      free     <= 1'b0;
      old      <= 1'b0;
      old_time <= TIME_MAX;
    end else if (step) begin
      if (ent_valid && !uhit && (unique_id != '0) && (ent_unique_id == unique_id)) begin
        uhit  <= 1'b1;
        uslot <= step_slot;
      end
      if (ent_valid && !shit && (ent_short_id == short_id)) begin
        shit  <= 1'b1;
        sslot <= step_slot;
      end
      if (!ent_valid && !free) begin
        free  <= 1'b1;
        fslot <= step_slot;
      end
      if (ent_valid && (ent_seen < old_time)) begin
        old      <= 1'b1;
        old_time <= ent_seen;
        oslot    <= step_slot;
      end
    end
  end

  always_comb begin
    disp = DISP_NOSPACE;
    slot = '0;
    if (uhit) begin
      disp = DISP_UNIQUE;
      slot = uslot;
    end else if (shit) begin
      disp = DISP_SHORT;
      slot = sslot;
    end else if (free) begin
      disp = DISP_CREATED;
      slot = fslot;
    end else if (old) begin
      disp = DISP_EVICTED;
      slot = oslot;
    end
  end

endmodule
